@@ design/ttsd_pkg.sv @@
// ttsd_pkg: shared types and constants for the triple tap sequence detector
// no dependencies; used by the interfaces and every design module
package ttsd_pkg;

    // field widths
    localparam int TIME_WIDTH = 32;
    localparam int MAG_WIDTH  = 16;
    localparam int CFG_DATA_W = 15;
    localparam int CFG_IDX_W  = 3;

    // fixed limits
    localparam logic [15:0] CEILING_MG   = 16'd20000;
    localparam logic [1:0]  SPREAD_RATIO = 2'd3;

    // verdict codes
    typedef enum logic [1:0] {
        V_SINGLE = 2'd0,
        V_DOUBLE = 2'd1,
        V_TRIPLE = 2'd2,
        V_REJECT = 2'd3
    } verdict_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        R_TAP_THRESHOLD   = 3'd0,
        R_VIBRATION_LIMIT = 3'd1,
        R_SEQUENCE_WINDOW = 3'd2,
        R_MIN_SPACING     = 3'd3,
        R_LOCKOUT         = 3'd4,
        R_BURST_WINDOW    = 3'd5,
        R_BURST_LIMIT     = 3'd6,
        R_SPREAD_FILTER   = 3'd7
    } cfg_idx_t;

    // configuration register file
    typedef struct packed {
        logic [12:0] tap_threshold_mg;
        logic [14:0] vibration_limit_mg;
        logic [10:0] sequence_window_ms;
        logic [8:0]  min_spacing_ms;
        logic [12:0] lockout_ms;
        logic [10:0] burst_window_ms;
        logic [1:0]  burst_limit;
        logic        spread_filter_on;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        tap_threshold_mg:   13'd1500,
        vibration_limit_mg: 15'd10000,
        sequence_window_ms: 11'd1000,
        min_spacing_ms:     9'd100,
        lockout_ms:         13'd2000,
        burst_window_ms:    11'd200,
        burst_limit:        2'd2,
        spread_filter_on:   1'b1
    };

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_LOCK,
        S_BASIC,
        S_START,
        S_BURST,
        S_WIN,
        S_T0,
        S_T1,
        S_T2,
        S_T3,
        S_T4,
        S_EMIT
    } state_t;

    // shared compare unit results
    typedef struct packed {
        logic [TIME_WIDTH-1:0] diff;
        logic                  a_lt_b;
        logic                  diff_lt_c;
        logic                  diff_gt_c;
    } cmp_res_t;

    // one result beat
    typedef struct packed {
        verdict_t   verdict;
        logic [1:0] count;
        logic       armed;
    } res_beat_t;

endpackage

@@ design/ttsd_if.sv @@
// ttsd_if: valid/ready channel interfaces for tap beats and result beats
// depends on ttsd_pkg for field widths

// tap input channel
interface ttsd_tap_if;
    logic                            valid;
    logic                            ready;
    logic [ttsd_pkg::TIME_WIDTH-1:0] tap_time_ms;
    logic [ttsd_pkg::MAG_WIDTH-1:0]  tap_magnitude_mg;

    modport source (output valid, tap_time_ms, tap_magnitude_mg, input ready);
    modport sink   (input valid, tap_time_ms, tap_magnitude_mg, output ready);
endinterface

// result output channel
interface ttsd_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] tap_verdict;
    logic [1:0] taps_in_sequence;
    logic       tap_armed;

    modport source (output valid, tap_verdict, taps_in_sequence, tap_armed,
                    input ready);
    modport sink   (input valid, tap_verdict, taps_in_sequence, tap_armed,
                    output ready);
endinterface

@@ design/triple_tap_sequence_detector_top.sv @@
// Each accepted tap beat yields exactly one result beat. The tap passes through the
// lockout check, which alone rejects a tap still in lockout, then the threshold,
// ceiling, vibration and spacing screen, which ends there on a reject, then the
// sequence window update and the result hand-off. While a sequence is open the
// burst look-back adds one step to form its start and one per stored tap scanned,
// and a third tap adds three span checks plus, with the spread filter on, two
// magnitude steps. These steps follow from the single shared subtract-and-compare
// unit, which the sequencer uses once per cycle. The input is ready only while the
// sequencer is idle, the cycle after each hand-off, so a new tap is taken only once
// the last one is handed off; a hand-off waits while the output register holds an
// unaccepted result. The result sits in that output register, so a new tap is taken
// while an earlier result waits. Configuration is written through cfg_we, cfg_index
// and cfg_wdata; the user must write it only while idle, the block does not enforce it.
//
// triple_tap_sequence_detector_top: config registers, output register, sequencer
// depends on ttsd_pkg, ttsd_if and ttsd_ctrl
module triple_tap_sequence_detector_top (
    input  logic                             clk,
    input  logic                             rst_n,
    ttsd_tap_if.sink                         tap_in,
    ttsd_res_if.source                       res_out,
    input  logic                             cfg_we,
    input  logic [ttsd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ttsd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import ttsd_pkg::*;

    cfg_t      cfg_reg, cfg_next;
    logic      out_valid_reg;
    res_beat_t out_beat_reg;
    logic      slot_free;
    logic      emit_valid;
    res_beat_t emit_beat;

    // configuration write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                R_TAP_THRESHOLD:   cfg_next.tap_threshold_mg   = cfg_wdata[12:0];
                R_VIBRATION_LIMIT: cfg_next.vibration_limit_mg = cfg_wdata[14:0];
                R_SEQUENCE_WINDOW: cfg_next.sequence_window_ms = cfg_wdata[10:0];
                R_MIN_SPACING:     cfg_next.min_spacing_ms     = cfg_wdata[8:0];
                R_LOCKOUT:         cfg_next.lockout_ms         = cfg_wdata[12:0];
                R_BURST_WINDOW:    cfg_next.burst_window_ms    = cfg_wdata[10:0];
                R_BURST_LIMIT:     cfg_next.burst_limit        = cfg_wdata[1:0];
                R_SPREAD_FILTER:   cfg_next.spread_filter_on   = cfg_wdata[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // sequencer
    ttsd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .tap_in     (tap_in),
        .cfg        (cfg_reg),
        .slot_free  (slot_free),
        .emit_valid (emit_valid),
        .emit_beat  (emit_beat)
    );

    // output register
    assign slot_free = !out_valid_reg || res_out.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_valid)
        begin
            out_beat_reg <= emit_beat;
        end
    end

    assign res_out.valid            = out_valid_reg;
    assign res_out.tap_verdict      = out_beat_reg.verdict;
    assign res_out.taps_in_sequence = out_beat_reg.count;
    assign res_out.tap_armed        = out_beat_reg.armed;

endmodule

@@ design/ttsd_cmp_unit.sv @@
// ttsd_cmp_unit: shared modular subtract and compare unit
// depends on ttsd_pkg; time-shared by the sequencer in ttsd_ctrl
module ttsd_cmp_unit (
    input  logic [ttsd_pkg::TIME_WIDTH-1:0] op_a,
    input  logic [ttsd_pkg::TIME_WIDTH-1:0] op_b,
    input  logic [ttsd_pkg::TIME_WIDTH-1:0] op_c,
    output ttsd_pkg::cmp_res_t              res
);
    import ttsd_pkg::*;

    logic [TIME_WIDTH:0] diff_ext;

    // one subtract, borrow gives a < b, wrapped difference compared with c
    always_comb
    begin
        diff_ext      = {1'b0, op_a} - {1'b0, op_b};
        res.diff      = diff_ext[TIME_WIDTH-1:0];
        res.a_lt_b    = diff_ext[TIME_WIDTH];
        res.diff_lt_c = diff_ext[TIME_WIDTH-1:0] < op_c;
        res.diff_gt_c = diff_ext[TIME_WIDTH-1:0] > op_c;
    end

endmodule

@@ design/ttsd_ctrl.sv @@
// ttsd_ctrl: tap judging sequencer, sequence state and stored taps
// depends on ttsd_pkg, ttsd_tap_if and ttsd_cmp_unit
module ttsd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    ttsd_tap_if.sink             tap_in,
    input  ttsd_pkg::cfg_t       cfg,
    input  logic                 slot_free,
    output logic                 emit_valid,
    output ttsd_pkg::res_beat_t  emit_beat
);
    import ttsd_pkg::*;

    state_t state_reg, state_next;

    // current tap
    logic [TIME_WIDTH-1:0] now_reg;
    logic [MAG_WIDTH-1:0]  mag_reg;

    // sequence and lockout state
    verdict_t              verdict_reg, verdict_next;
    logic                  seq_active_reg, seq_active_next;
    logic [1:0]            seq_count_reg, seq_count_next;
    logic [TIME_WIDTH-1:0] seq_start_reg, seq_start_next;
    logic [TIME_WIDTH-1:0] last_tap_reg, last_tap_next;
    logic                  lockout_reg, lockout_next;
    logic [TIME_WIDTH-1:0] last_detect_reg, last_detect_next;
    logic                  armed_reg, armed_next;

    // burst scan and spread working registers
    logic [TIME_WIDTH-1:0] start_reg, start_next;
    logic [1:0]            idx_reg, idx_next;
    logic [1:0]            rapid_reg, rapid_next;
    logic [MAG_WIDTH-1:0]  lo_reg, lo_next;
    logic [MAG_WIDTH-1:0]  hi_reg, hi_next;

    // stored taps of the current sequence
    logic [TIME_WIDTH-1:0] times_reg [0:2];
    logic [MAG_WIDTH-1:0]  mags_reg  [0:2];
    logic                  store_en;
    logic [1:0]            store_idx;

    // shared unit
    logic [TIME_WIDTH-1:0] op_a, op_b, op_c;
    cmp_res_t              res;

    // decisions
    logic                  accept;
    logic                  lock_hold;
    logic                  basic_rej;
    logic                  hit;
    logic [1:0]            rapid_sum;
    logic                  burst_last;
    logic                  burst_rej;
    logic                  act_eff;
    logic [1:0]            cnt_eff;
    logic                  win_full;
    logic [1:0]            new_count;
    logic                  spread_bad;
    logic                  tri_fail;
    logic                  tri_pass;
    logic                  seq_clear;
    logic [MAG_WIDTH-1:0]  lo_mag, hi_mag;

    assign tap_in.ready = (state_reg == S_IDLE);
    assign accept       = tap_in.valid && tap_in.ready;

    ttsd_cmp_unit u_cmp (
        .op_a (op_a),
        .op_b (op_b),
        .op_c (op_c),
        .res  (res)
    );

    // operand select for the shared unit
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        op_c = '0;
        unique case (state_reg)
            S_LOCK:
            begin
                op_a = now_reg;
                op_b = last_detect_reg;
                op_c = TIME_WIDTH'(cfg.lockout_ms);
            end
            S_BASIC:
            begin
                op_a = now_reg;
                op_b = last_tap_reg;
                op_c = TIME_WIDTH'(cfg.min_spacing_ms);
            end
            S_START:
            begin
                op_a = now_reg;
                op_b = TIME_WIDTH'(cfg.burst_window_ms);
            end
            S_BURST:
            begin
                op_a = times_reg[idx_reg];
                op_b = start_reg;
            end
            S_WIN:
            begin
                op_a = now_reg;
                op_b = seq_start_reg;
                op_c = TIME_WIDTH'(cfg.sequence_window_ms);
            end
            S_T0:
            begin
                op_a = times_reg[2];
                op_b = times_reg[0];
                op_c = TIME_WIDTH'(cfg.sequence_window_ms);
            end
            S_T1:
            begin
                op_a = times_reg[1];
                op_b = times_reg[0];
                op_c = TIME_WIDTH'(cfg.min_spacing_ms);
            end
            S_T2:
            begin
                op_a = times_reg[2];
                op_b = times_reg[1];
                op_c = TIME_WIDTH'(cfg.min_spacing_ms);
            end
            default:
            begin
                op_a = '0;
            end
        endcase
    end

    // decision flags
    always_comb
    begin
        lock_hold  = lockout_reg && res.diff_lt_c;
        basic_rej  = (32'(mag_reg) < 32'(cfg.tap_threshold_mg))
                  || (now_reg == '0)
                  || (32'(mag_reg) > 32'(CEILING_MG))
                  || ((last_tap_reg != '0) && res.diff_lt_c)
                  || (32'(mag_reg) > 32'(cfg.vibration_limit_mg));
        hit        = !res.a_lt_b;
        rapid_sum  = rapid_reg + {1'b0, hit};
        burst_last = (idx_reg == (seq_count_reg - 2'd1)) || (idx_reg == 2'd2);
        burst_rej  = rapid_sum >= cfg.burst_limit;
        act_eff    = seq_active_reg && !res.diff_gt_c;
        cnt_eff    = act_eff ? seq_count_reg : 2'd0;
        win_full   = (cnt_eff == 2'd3);
        new_count  = cnt_eff + 2'd1;
        spread_bad = (MAG_WIDTH+2)'(hi_reg)
                   > ((MAG_WIDTH+2)'(lo_reg) * (MAG_WIDTH+2)'(SPREAD_RATIO));
        tri_fail   = ((state_reg == S_T0) && res.diff_gt_c)
                  || (((state_reg == S_T1) || (state_reg == S_T2)) && res.diff_lt_c)
                  || ((state_reg == S_T4) && spread_bad);
        tri_pass   = ((state_reg == S_T2) && !res.diff_lt_c && !cfg.spread_filter_on)
                  || ((state_reg == S_T4) && !spread_bad);
        seq_clear  = tri_fail || tri_pass || ((state_reg == S_WIN) && win_full);
    end

    // min and max of the three stored magnitudes
    always_comb
    begin
        lo_mag = mags_reg[0];
        hi_mag = mags_reg[0];
        if (mags_reg[1] < lo_mag)
        begin
            lo_mag = mags_reg[1];
        end
        if (mags_reg[1] > hi_mag)
        begin
            hi_mag = mags_reg[1];
        end
        if (mags_reg[2] < lo_mag)
        begin
            lo_mag = mags_reg[2];
        end
        if (mags_reg[2] > hi_mag)
        begin
            hi_mag = mags_reg[2];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_LOCK;
                end
            end
            S_LOCK:
            begin
                state_next = lock_hold ? S_EMIT : S_BASIC;
            end
            S_BASIC:
            begin
                if (basic_rej)
                begin
                    state_next = S_EMIT;
                end
                else if (seq_count_reg != 2'd0)
                begin
                    state_next = S_START;
                end
                else
                begin
                    state_next = S_WIN;
                end
            end
            S_START:
            begin
                state_next = S_BURST;
            end
            S_BURST:
            begin
                if (burst_last)
                begin
                    state_next = burst_rej ? S_EMIT : S_WIN;
                end
            end
            S_WIN:
            begin
                state_next = (win_full || (new_count != 2'd3)) ? S_EMIT : S_T0;
            end
            S_T0:
            begin
                state_next = tri_fail ? S_EMIT : S_T1;
            end
            S_T1:
            begin
                state_next = tri_fail ? S_EMIT : S_T2;
            end
            S_T2:
            begin
                state_next = (tri_fail || tri_pass) ? S_EMIT : S_T3;
            end
            S_T3:
            begin
                state_next = S_T4;
            end
            S_T4:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath updates per state
    always_comb
    begin
        verdict_next     = verdict_reg;
        seq_active_next  = seq_active_reg;
        seq_count_next   = seq_count_reg;
        seq_start_next   = seq_start_reg;
        last_tap_next    = last_tap_reg;
        lockout_next     = lockout_reg;
        last_detect_next = last_detect_reg;
        armed_next       = armed_reg;
        start_next       = start_reg;
        idx_next         = idx_reg;
        rapid_next       = rapid_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        store_en         = 1'b0;
        store_idx        = cnt_eff;

        unique case (state_reg)
            S_LOCK:
            begin
                if (lock_hold)
                begin
                    verdict_next = V_REJECT;
                end
                else if (lockout_reg)
                begin
                    lockout_next = 1'b0;
                    armed_next   = 1'b1;
                end
            end
            S_BASIC:
            begin
                if (basic_rej)
                begin
                    verdict_next = V_REJECT;
                end
            end
            S_START:
            begin
                start_next = res.diff;
                idx_next   = 2'd0;
                rapid_next = 2'd0;
            end
            S_BURST:
            begin
                rapid_next = rapid_sum;
                idx_next   = idx_reg + 2'd1;
                if (burst_last && burst_rej)
                begin
                    verdict_next = V_REJECT;
                end
            end
            S_WIN:
            begin
                if (win_full)
                begin
                    verdict_next = V_REJECT;
                end
                else
                begin
                    seq_active_next = 1'b1;
                    if (!act_eff)
                    begin
                        seq_start_next = now_reg;
                    end
                    seq_count_next = new_count;
                    last_tap_next  = now_reg;
                    store_en       = 1'b1;
                    if (new_count == 2'd1)
                    begin
                        verdict_next = V_SINGLE;
                    end
                    else if (new_count == 2'd2)
                    begin
                        verdict_next = V_DOUBLE;
                    end
                end
            end
            S_T3:
            begin
                lo_next = lo_mag;
                hi_next = hi_mag;
            end
            default:
            begin
                store_en = 1'b0;
            end
        endcase

        // triple outcome
        if (tri_fail)
        begin
            verdict_next = V_REJECT;
        end
        if (tri_pass)
        begin
            verdict_next     = V_TRIPLE;
            last_detect_next = now_reg;
            lockout_next     = 1'b1;
            armed_next       = 1'b0;
        end

        // sequence cleared after a triple attempt or an overfull sequence
        if (seq_clear)
        begin
            seq_active_next = 1'b0;
            seq_count_next  = 2'd0;
            seq_start_next  = '0;
            last_tap_next   = '0;
        end
    end

    // control and sequence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            verdict_reg     <= V_SINGLE;
            seq_active_reg  <= 1'b0;
            seq_count_reg   <= 2'd0;
            seq_start_reg   <= '0;
            last_tap_reg    <= '0;
            lockout_reg     <= 1'b0;
            last_detect_reg <= '0;
            armed_reg       <= 1'b1;
            idx_reg         <= 2'd0;
            rapid_reg       <= 2'd0;
        end
        else
        begin
            state_reg       <= state_next;
            verdict_reg     <= verdict_next;
            seq_active_reg  <= seq_active_next;
            seq_count_reg   <= seq_count_next;
            seq_start_reg   <= seq_start_next;
            last_tap_reg    <= last_tap_next;
            lockout_reg     <= lockout_next;
            last_detect_reg <= last_detect_next;
            armed_reg       <= armed_next;
            idx_reg         <= idx_next;
            rapid_reg       <= rapid_next;
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            now_reg <= tap_in.tap_time_ms;
            mag_reg <= tap_in.tap_magnitude_mg;
        end
        start_reg <= start_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
    end

    // stored tap slots
    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            times_reg[store_idx] <= now_reg;
            mags_reg[store_idx]  <= mag_reg;
        end
    end

    // result beat toward the output register
    assign emit_valid        = (state_reg == S_EMIT) && slot_free;
    assign emit_beat.verdict = verdict_reg;
    assign emit_beat.count   = seq_count_reg;
    assign emit_beat.armed   = armed_reg;

    // an accepted tap always starts with the lockout check
    a_accept_to_lock: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_LOCK))
        else $error("accepted tap did not enter lockout check");

    // a result is only handed over when the output register can take it
    a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        emit_valid |-> slot_free)
        else $error("result emitted into a full output register");

    // between taps a sequence never keeps three taps
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (seq_count_reg != 2'd3))
        else $error("sequence holds three taps between beats");

    // armed is exactly the inverse of lockout
    a_armed_lock: assert property (@(posedge clk) disable iff (!rst_n)
        armed_reg != lockout_reg)
        else $error("armed flag and lockout disagree");

    // a triple verdict comes with lockout set
    a_triple_lock: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_valid && (verdict_reg == V_TRIPLE)) |-> lockout_reg)
        else $error("triple reported without lockout");

endmodule

@@ tb/triple_tap_sequence_detector_top_test.sv @@
`timescale 1ns / 1ps
// triple_tap_sequence_detector_top_test: self-checking bench for the tap sequence detector
// walks a directed tap table, then random tap streams over several register settings
// depends on ttsd_pkg, ttsd_if and triple_tap_sequence_detector_top
module triple_tap_sequence_detector_top_test;
    import ttsd_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int SETTLE_CYCLES  = 20;
    localparam int RANDOM_PHASES  = 5;
    localparam int TAPS_PER_PHASE = 110;
    localparam logic FIXED = 1'b1;
    localparam logic FREE  = 1'b0;

    // one row of tap stimulus, with the verdict typed in where it is obvious
    typedef struct packed {
        logic [TIME_WIDTH-1:0] time_ms;
        logic [MAG_WIDTH-1:0]  mag_mg;
        logic                  fixed;
        verdict_t              verdict;
        logic [1:0]            count;
        logic                  armed;
    } tap_row_t;

    localparam int DIRECTED_ROWS = 24;
    localparam tap_row_t DIRECTED [DIRECTED_ROWS] = '{
        // zero timestamp, then magnitude screens against threshold, ceiling, vibration
        '{32'd0,          16'd2000,  FIXED, V_REJECT, 2'd0, 1'b1},
        '{32'd1000,       16'd1499,  FIXED, V_REJECT, 2'd0, 1'b1},
        '{32'd1000,       16'd0,     FIXED, V_REJECT, 2'd0, 1'b1},
        '{32'd1000,       16'd65535, FIXED, V_REJECT, 2'd0, 1'b1},
        '{32'd1000,       16'd20000, FIXED, V_REJECT, 2'd0, 1'b1},
        // exactly at the vibration limit still counts
        '{32'd1000,       16'd10000, FIXED, V_SINGLE, 2'd1, 1'b1},
        // too soon after the previous tap
        '{32'd1050,       16'd3400,  FIXED, V_REJECT, 2'd1, 1'b1},
        '{32'd1400,       16'd3400,  FREE,  V_SINGLE, 2'd0, 1'b0},
        '{32'd1600,       16'd3400,  FREE,  V_SINGLE, 2'd0, 1'b0},
        // inside lockout after the triple
        '{32'd2000,       16'd3000,  FIXED, V_REJECT, 2'd0, 1'b0},
        // lockout ends exactly here
        '{32'd3600,       16'd3000,  FREE,  V_SINGLE, 2'd0, 1'b0},
        '{32'd3800,       16'd9000,  FREE,  V_SINGLE, 2'd0, 1'b0},
        // spread just over 3x fails the triple
        '{32'd4000,       16'd2999,  FREE,  V_SINGLE, 2'd0, 1'b0},
        '{32'd4200,       16'd3000,  FREE,  V_SINGLE, 2'd0, 1'b0},
        '{32'd4300,       16'd3000,  FREE,  V_SINGLE, 2'd0, 1'b0},
        // two stored taps in the look-back span
        '{32'd4400,       16'd3000,  FREE,  V_SINGLE, 2'd0, 1'b0},
        // sequence window expired, starts over
        '{32'd5300,       16'd3000,  FREE,  V_SINGLE, 2'd0, 1'b0},
        '{32'd5550,       16'd3000,  FREE,  V_SINGLE, 2'd0, 1'b0},
        // spread of exactly 3x passes
        '{32'd5800,       16'd9000,  FREE,  V_SINGLE, 2'd0, 1'b0},
        // one ms short of lockout end
        '{32'd7799,       16'd3000,  FIXED, V_REJECT, 2'd0, 1'b0},
        // timestamp wrap
        '{32'hFFFF_FFF0,  16'd3000,  FREE,  V_SINGLE, 2'd0, 1'b0},
        '{32'hFFFF_FFFF,  16'd3000,  FIXED, V_REJECT, 2'd1, 1'b1},
        '{32'h0000_0040,  16'd3000,  FREE,  V_SINGLE, 2'd0, 1'b0},
        '{32'h0000_0060,  16'd3000,  FREE,  V_SINGLE, 2'd0, 1'b0}
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    ttsd_tap_if tap_ch ();
    ttsd_res_if res_ch ();

    triple_tap_sequence_detector_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .tap_in    (tap_ch),
        .res_out   (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // detector model state
    cfg_t                  tap_cfg = CFG_RESET;
    logic                  seq_open = 1'b0;
    logic [1:0]            seq_taps = 2'd0;
    logic [TIME_WIDTH-1:0] seq_start_ms = '0;
    logic [TIME_WIDTH-1:0] prev_tap_ms = '0;
    logic [TIME_WIDTH-1:0] detect_ms = '0;
    logic [TIME_WIDTH-1:0] held_times [3] = '{default: '0};
    logic [MAG_WIDTH-1:0]  held_mags [3] = '{default: '0};
    logic                  locked_out = 1'b0;
    logic                  armed = 1'b1;

    res_beat_t pending_verdicts [$];
    int        mismatches = 0;
    int        cycle_count = 0;
    int        src_idle_pct = 0;
    int        snk_idle_pct = 0;
    logic [TIME_WIDTH-1:0] wall_ms;

    // clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void drop_sequence();
        seq_open = 1'b0;
        seq_taps = 2'd0;
        seq_start_ms = '0;
        prev_tap_ms = '0;
        held_times = '{default: '0};
        held_mags = '{default: '0};
    endfunction

    // span, both intervals and, with the filter on, max <= 3 * min
    function automatic logic triple_holds();
        logic [MAG_WIDTH+1:0] lo;
        logic [MAG_WIDTH+1:0] hi;
        if (held_times[2] - held_times[0] > tap_cfg.sequence_window_ms)
            return 1'b0;
        if (held_times[1] - held_times[0] < tap_cfg.min_spacing_ms)
            return 1'b0;
        if (held_times[2] - held_times[1] < tap_cfg.min_spacing_ms)
            return 1'b0;
        if (tap_cfg.spread_filter_on)
        begin
            lo = (MAG_WIDTH+2)'(held_mags[0]);
            hi = (MAG_WIDTH+2)'(held_mags[0]);
            for (int i = 1; i < 3; i++)
            begin
                if ((MAG_WIDTH+2)'(held_mags[i]) < lo)
                    lo = (MAG_WIDTH+2)'(held_mags[i]);
                if ((MAG_WIDTH+2)'(held_mags[i]) > hi)
                    hi = (MAG_WIDTH+2)'(held_mags[i]);
            end
            if (hi > lo * (MAG_WIDTH+2)'(SPREAD_RATIO))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // verdict for one tap, updating the model state
    function automatic verdict_t score_tap(input logic [TIME_WIDTH-1:0] now,
                                           input logic [MAG_WIDTH-1:0] mag);
        int                    rapid;
        logic [TIME_WIDTH-1:0] look_start;
        verdict_t              v;
        if (locked_out)
        begin
            if (now - detect_ms < tap_cfg.lockout_ms)
                return V_REJECT;
            locked_out = 1'b0;
            armed = 1'b1;
        end
        if (mag < tap_cfg.tap_threshold_mg || now == 0 || mag > CEILING_MG)
            return V_REJECT;
        if (prev_tap_ms != 0 && now - prev_tap_ms < tap_cfg.min_spacing_ms)
            return V_REJECT;
        if (mag > tap_cfg.vibration_limit_mg)
            return V_REJECT;
        // vibration: too many stored taps in the look-back span
        if (seq_taps != 0)
        begin
            rapid = 0;
            look_start = now - TIME_WIDTH'(tap_cfg.burst_window_ms);
            for (int i = 0; i < 3; i++)
                if (i < seq_taps && held_times[i] >= look_start)
                    rapid++;
            if (rapid >= int'(tap_cfg.burst_limit))
                return V_REJECT;
        end
        if (seq_open && now - seq_start_ms > tap_cfg.sequence_window_ms)
            drop_sequence();
        if (!seq_open)
        begin
            seq_start_ms = now;
            seq_open = 1'b1;
            seq_taps = 2'd0;
        end
        held_times[seq_taps] = now;
        held_mags[seq_taps] = mag;
        seq_taps++;
        prev_tap_ms = now;
        if (seq_taps == 2'd1)
            return V_SINGLE;
        if (seq_taps == 2'd2)
            return V_DOUBLE;
        v = V_REJECT;
        if (triple_holds())
        begin
            v = V_TRIPLE;
            detect_ms = now;
            locked_out = 1'b1;
            armed = 1'b0;
        end
        drop_sequence();
        return v;
    endfunction

    function automatic void note_mismatch(input string what, input int want, input int got);
        mismatches++;
        $display("%0t %s mismatch: expected %0d, actual %0d", $time, what, want, got);
    endfunction

    // send one tap beat, then queue its expected result
    task automatic run_tap(input tap_row_t row);
        res_beat_t want;
        while ($urandom_range(99) < src_idle_pct)
        begin
            tap_ch.valid <= 1'b0;
            @(posedge clk);
        end
        tap_ch.valid <= 1'b1;
        tap_ch.tap_time_ms <= row.time_ms;
        tap_ch.tap_magnitude_mg <= row.mag_mg;
        @(posedge clk);
        while (!tap_ch.ready)
            @(posedge clk);
        want.verdict = score_tap(row.time_ms, row.mag_mg);
        want.count = seq_taps;
        want.armed = armed;
        if (row.fixed)
        begin
            want.verdict = row.verdict;
            want.count = row.count;
            want.armed = row.armed;
        end
        pending_verdicts.push_back(want);
    endtask

    // stop sending and let every result come back
    task automatic drain_results();
        tap_ch.valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        case (idx)
            R_TAP_THRESHOLD:   tap_cfg.tap_threshold_mg = value[12:0];
            R_VIBRATION_LIMIT: tap_cfg.vibration_limit_mg = value[14:0];
            R_SEQUENCE_WINDOW: tap_cfg.sequence_window_ms = value[10:0];
            R_MIN_SPACING:     tap_cfg.min_spacing_ms = value[8:0];
            R_LOCKOUT:         tap_cfg.lockout_ms = value[12:0];
            R_BURST_WINDOW:    tap_cfg.burst_window_ms = value[10:0];
            R_BURST_LIMIT:     tap_cfg.burst_limit = value[1:0];
            R_SPREAD_FILTER:   tap_cfg.spread_filter_on = value[0];
            default:           ;
        endcase
    endtask

    task automatic program_regs(input logic [CFG_DATA_W-1:0] thr, vib, win, spc,
                                input logic [CFG_DATA_W-1:0] lock, bwin, blim, filt);
        write_reg(R_TAP_THRESHOLD, thr);
        write_reg(R_VIBRATION_LIMIT, vib);
        write_reg(R_SEQUENCE_WINDOW, win);
        write_reg(R_MIN_SPACING, spc);
        write_reg(R_LOCKOUT, lock);
        write_reg(R_BURST_WINDOW, bwin);
        write_reg(R_BURST_LIMIT, blim);
        write_reg(R_SPREAD_FILTER, filt);
        cfg_we <= 1'b0;
    endtask

    // result checking and random receiver stalls
    always @(posedge clk)
    begin : result_check
        res_beat_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                mismatches++;
                $display("%0t result beat with none expected: expected none, actual verdict %0d",
                         $time, res_ch.tap_verdict);
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (res_ch.tap_verdict !== want.verdict)
                    note_mismatch("tap_verdict", int'(want.verdict),
                                  int'(res_ch.tap_verdict));
                if (res_ch.taps_in_sequence !== want.count)
                    note_mismatch("taps_in_sequence", int'(want.count),
                                  int'(res_ch.taps_in_sequence));
                if (res_ch.tap_armed !== want.armed)
                    note_mismatch("tap_armed", int'(want.armed), int'(res_ch.tap_armed));
            end
        end
        res_ch.ready <= rst_n && ($urandom_range(99) >= snk_idle_pct);
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        tap_row_t              row;
        logic [TIME_WIDTH-1:0] t;
        logic [MAG_WIDTH-1:0]  m;
        int                    pick;
        int                    spc_ms;
        int                    win_ms;
        int                    lock_ms;
        int                    lo_mg;
        int                    top_mg;

        tap_ch.valid <= 1'b0;
        tap_ch.tap_time_ms <= '0;
        tap_ch.tap_magnitude_mg <= '0;
        cfg_we <= 1'b0;
        cfg_index <= R_TAP_THRESHOLD;
        cfg_wdata <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table at reset settings
        src_idle_pct = 32;
        snk_idle_pct = 49;
        for (int i = 0; i < DIRECTED_ROWS; i++)
            run_tap(DIRECTED[i]);
        drain_results();
        wall_ms = DIRECTED[DIRECTED_ROWS-1].time_ms;

        // random tap streams, one register setting per phase
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0: program_regs(1500, 10000, 1000, 100, 2000, 200, 2, 1);
                1: program_regs(500, 500, 200, 50, 500, 0, 1, 0);
                2: program_regs(5000, 20000, 2000, 500, 5000, 2000, 3, 1);
                // all ones, the block keeps only each register's width
                3: program_regs('1, '1, '1, '1, '1, '1, '1, '1);
                default: program_regs(CFG_DATA_W'($urandom_range(500, 5000)),
                                      CFG_DATA_W'($urandom_range(500, 20000)),
                                      CFG_DATA_W'($urandom_range(200, 2000)),
                                      CFG_DATA_W'($urandom_range(50, 500)),
                                      CFG_DATA_W'($urandom_range(500, 5000)),
                                      CFG_DATA_W'($urandom_range(0, 2000)),
                                      CFG_DATA_W'($urandom_range(0, 3)),
                                      CFG_DATA_W'($urandom_range(0, 1)));
            endcase
            src_idle_pct = (p < 2) ? 32 : (p < 4) ? 49 : 0;
            snk_idle_pct = (p < 2) ? 49 : (p < 4) ? 32 : 0;
            spc_ms = int'(tap_cfg.min_spacing_ms);
            win_ms = int'(tap_cfg.sequence_window_ms);
            lock_ms = int'(tap_cfg.lockout_ms);
            lo_mg = int'(tap_cfg.tap_threshold_mg);
            top_mg = (int'(tap_cfg.vibration_limit_mg) < int'(CEILING_MG)) ?
                     int'(tap_cfg.vibration_limit_mg) : int'(CEILING_MG);
            if (top_mg < lo_mg)
                top_mg = lo_mg;

            for (int n = 0; n < TAPS_PER_PHASE; n++)
            begin
                // timestamp: mostly plausible spacing, some too soon, long gaps, jumps, zero
                pick = $urandom_range(99);
                if (pick < 3)
                    t = '0;
                else if (pick < 8)
                begin
                    wall_ms = $urandom();
                    t = wall_ms;
                end
                else
                begin
                    pick = $urandom_range(99);
                    if (pick < 10)
                        wall_ms += $urandom_range(0, spc_ms);
                    else if (pick < 88)
                        wall_ms += $urandom_range(spc_ms, spc_ms + win_ms / 2 + 50);
                    else
                        wall_ms += $urandom_range(win_ms, lock_ms + win_ms);
                    t = wall_ms;
                end

                // magnitude: mostly valid taps, a tight band for the spread test, some noise
                pick = $urandom_range(99);
                if (pick < 12)
                    m = MAG_WIDTH'($urandom_range(0, 65535));
                else if (pick < 55)
                    m = MAG_WIDTH'($urandom_range(lo_mg,
                                                  (2 * lo_mg < top_mg) ? 2 * lo_mg : top_mg));
                else
                    m = MAG_WIDTH'($urandom_range(lo_mg, top_mg));

                row = '{t, m, FREE, V_SINGLE, 2'd0, 1'b0};
                run_tap(row);
            end
            drain_results();
        end

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
